### hdl/tccc_pkg.sv
package tccc_pkg;

  localparam int unsigned TimeW = 62;   // strike / event timestamps
  localparam int unsigned WideW = 63;   // deadlines, clip bounds
  localparam int unsigned CfgW  = 40;   // configuration registers
  localparam int unsigned IdW   = 32;   // clip ids
  localparam int unsigned IdxW  = 3;    // configuration register index

  // controller mode, one-hot
  typedef enum logic [2:0] {
    MODE_READY = 3'b001,
    MODE_WAIT  = 3'b010,
    MODE_COOL  = 3'b100
  } mode_t;

  // session_state codes on the result
  localparam logic [1:0] SESS_READY = 2'd0;
  localparam logic [1:0] SESS_WAIT  = 2'd1;
  localparam logic [1:0] SESS_COOL  = 2'd2;

  typedef enum logic [3:0] {
    DISP_ACCEPTED       = 4'd0,
    DISP_IGN_PENDING    = 4'd1,
    DISP_IGN_COOLDOWN   = 4'd2,
    DISP_PREROLL_GONE   = 4'd3,
    DISP_NONE_PENDING   = 4'd4,
    DISP_WAITING        = 4'd5,
    DISP_EXPIRED        = 4'd6,
    DISP_FREEZE         = 4'd7,
    DISP_TIME_BACKWARDS = 4'd8,
    DISP_CONFIRM_EARLY  = 4'd9,
    DISP_CFG_INVALID    = 4'd10
  } disp_t;

  typedef enum logic [IdxW-1:0] {
    CFG_LEAD_SPAN       = 3'd0,
    CFG_TAIL_SPAN       = 3'd1,
    CFG_BOUNDARY_MARGIN = 3'd2,
    CFG_RING_RETENTION  = 3'd3,
    CFG_COOLDOWN_LENGTH = 3'd4
  } cfg_idx_t;

  // request type
  localparam logic REQ_TRIGGER = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  // configuration as seen by the decision logic, with derived terms
  typedef struct packed {
    logic [CfgW-1:0] lead_span;
    logic [CfgW-1:0] tail_span;
    logic [CfgW-1:0] cooldown_length;
    logic [CfgW:0]   post_margin;  // tail_span + boundary_margin
    logic [CfgW-1:0] slack;        // ring_retention - boundary_margin - lead_span
    logic            ok;           // ring holds lead + tail + 2 * margin
  } cfg_t;

endpackage

### hdl/tccc_cfg.sv
module tccc_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tccc_pkg::IdxW-1:0]      cfg_index,
  input  logic [tccc_pkg::CfgW-1:0]      cfg_data,
  output tccc_pkg::cfg_t                 cfg
);

  logic [tccc_pkg::CfgW-1:0] lead_span;
  logic [tccc_pkg::CfgW-1:0] tail_span;
  logic [tccc_pkg::CfgW-1:0] boundary_margin;
  logic [tccc_pkg::CfgW-1:0] ring_retention;
  logic [tccc_pkg::CfgW-1:0] cooldown_length;
  logic [tccc_pkg::CfgW+2:0] need;
  logic [tccc_pkg::CfgW+1:0] slack_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_span       <= '0;
      tail_span       <= '0;
      boundary_margin <= '0;
      ring_retention  <= '0;
      cooldown_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tccc_pkg::CFG_LEAD_SPAN:       lead_span       <= cfg_data;
        tccc_pkg::CFG_TAIL_SPAN:       tail_span       <= cfg_data;
        tccc_pkg::CFG_BOUNDARY_MARGIN: boundary_margin <= cfg_data;
        tccc_pkg::CFG_RING_RETENTION:  ring_retention  <= cfg_data;
        tccc_pkg::CFG_COOLDOWN_LENGTH: cooldown_length <= cfg_data;
        default: ;
      endcase
    end
  end

  assign need = {3'b000, lead_span} + {3'b000, tail_span} + {2'b00, boundary_margin, 1'b0};
  assign slack_full = {2'b00, ring_retention} - {2'b00, boundary_margin} - {2'b00, lead_span};

  // derived terms are registered after a write; user must hold requests off until then
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{default: '0, ok: 1'b1};
    end else begin
      cfg.lead_span       <= lead_span;
      cfg.tail_span       <= tail_span;
      cfg.cooldown_length <= cooldown_length;
      cfg.post_margin     <= {1'b0, tail_span} + {1'b0, boundary_margin};
      cfg.slack           <= slack_full[tccc_pkg::CfgW-1:0];
      cfg.ok              <= {3'b000, ring_retention} >= need;
    end
  end

endmodule

### hdl/triggered_clip_capture_controller_top.sv
// Trigger controller for a capture ring. Each request is a trigger (strike and
// confirmation time) or a tick (current time) and yields exactly one result.
// A request is held in the input register; the decision, the state
// update and the result register load happen together on the edge at
// which it is decided, so a new request is taken every cycle while the
// result channel is not stalled; its result is loaded from there straight
// into the result register. The result register lets the next request
// in while a result waits under out_stall. Configuration writes are
// always ready; derived terms (ring check, slack, post+margin) are
// registered in the cycle after the write, which is inside the idle gap
// required before the next request. Errors (bad config, confirm before
// strike, time running backwards) leave all state untouched and report the unchanged session state.
module triggered_clip_capture_controller_top (
  input  logic                              clk,
  input  logic                              rst,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              req_type,
  input  logic [tccc_pkg::TimeW-1:0]        hit_time,
  input  logic [tccc_pkg::TimeW-1:0]        event_time,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [3:0]                        disposition,
  output logic [tccc_pkg::IdW-1:0]          clip_id,
  output logic                              freeze_valid,
  output logic [tccc_pkg::TimeW-1:0]        freeze_strike,
  output logic [tccc_pkg::TimeW-1:0]        freeze_confirm,
  output logic signed [tccc_pkg::WideW-1:0] clip_start,
  output logic [tccc_pkg::WideW-1:0]        clip_end,
  output logic [1:0]                        session_state,
  output logic [tccc_pkg::WideW-1:0]        pending_deadline,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tccc_pkg::IdxW-1:0]         cfg_index,
  input  logic [tccc_pkg::CfgW-1:0]         cfg_data
);

  tccc_pkg::cfg_t cfg;

  tccc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // ---------------- input register ----------------
  logic                       s1_valid;
  logic                       s1_type;
  logic [tccc_pkg::TimeW-1:0] s1_strike;
  logic [tccc_pkg::TimeW-1:0] s1_time;
  logic                       step;   // s1 request is decided this edge

  assign step     = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !step;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_type   <= req_type;
      s1_strike <= hit_time;
      s1_time   <= event_time;
    end
  end

  // ---------------- controller state ----------------
  tccc_pkg::mode_t            mode, mode_next;
  logic [tccc_pkg::IdW-1:0]   next_id, next_id_next;
  logic [tccc_pkg::IdW-1:0]   pending_id, pending_id_next;
  logic [tccc_pkg::IdW-1:0]   last_frozen_id, last_frozen_id_next;
  logic [tccc_pkg::TimeW-1:0] held_strike, held_strike_next;
  logic [tccc_pkg::TimeW-1:0] held_confirm, held_confirm_next;
  logic [tccc_pkg::WideW-1:0] deadline, deadline_next;
  logic [tccc_pkg::WideW-1:0] cooldown_end, cooldown_end_next;
  logic                       seen_time, seen_time_next;
  logic [tccc_pkg::TimeW-1:0] last_time, last_time_next;

  // decision results
  tccc_pkg::disp_t            r_disp;
  logic [tccc_pkg::IdW-1:0]   r_id;
  logic                       r_freeze;
  logic [tccc_pkg::WideW-1:0] r_start;
  logic [tccc_pkg::WideW-1:0] r_end;
  logic [1:0]                 r_sess;
  logic [tccc_pkg::WideW-1:0] r_pdl;

  // shared terms
  logic [tccc_pkg::WideW-1:0] now_w;
  logic                       cool_over;
  tccc_pkg::mode_t            mode_eff;
  logic [tccc_pkg::TimeW-1:0] age_new;   // confirm - strike of a trigger
  logic [tccc_pkg::TimeW-1:0] age_held;  // now - held strike
  logic [tccc_pkg::TimeW-1:0] slack_w;

  assign now_w     = {1'b0, s1_time};
  assign cool_over = now_w >= cooldown_end;
  assign mode_eff  = (mode == tccc_pkg::MODE_COOL && cool_over) ? tccc_pkg::MODE_READY : mode;
  assign age_new   = s1_time - s1_strike;
  assign age_held  = s1_time - held_strike;
  assign slack_w   = {{(tccc_pkg::TimeW - tccc_pkg::CfgW){1'b0}}, cfg.slack};

  always_comb begin
    mode_next           = mode;
    next_id_next        = next_id;
    pending_id_next     = pending_id;
    last_frozen_id_next = last_frozen_id;
    held_strike_next    = held_strike;
    held_confirm_next   = held_confirm;
    deadline_next       = deadline;
    cooldown_end_next   = cooldown_end;
    seen_time_next      = seen_time;
    last_time_next      = last_time;
    r_disp   = tccc_pkg::DISP_CFG_INVALID;
    r_id     = '0;
    r_freeze = 1'b0;
    r_start  = '0;
    r_end    = '0;

    if (!cfg.ok) begin
      r_disp = tccc_pkg::DISP_CFG_INVALID;
    end else if (s1_type == tccc_pkg::REQ_TRIGGER && s1_time < s1_strike) begin
      r_disp = tccc_pkg::DISP_CONFIRM_EARLY;
    end else if (seen_time && s1_time < last_time) begin
      r_disp = tccc_pkg::DISP_TIME_BACKWARDS;
    end else begin
      seen_time_next = 1'b1;
      last_time_next = s1_time;
      mode_next      = mode_eff;
      if (s1_type == tccc_pkg::REQ_TRIGGER) begin
        if (mode_eff == tccc_pkg::MODE_WAIT) begin
          r_disp = tccc_pkg::DISP_IGN_PENDING;
          r_id   = pending_id;
        end else if (mode_eff == tccc_pkg::MODE_COOL) begin
          r_disp = tccc_pkg::DISP_IGN_COOLDOWN;
          r_id   = last_frozen_id;
        end else if (age_new > slack_w) begin
          // pre-roll already rolled out of the ring
          r_disp = tccc_pkg::DISP_PREROLL_GONE;
        end else begin
          r_disp            = tccc_pkg::DISP_ACCEPTED;
          r_id              = next_id;
          pending_id_next   = next_id;
          next_id_next      = (next_id == '1) ? tccc_pkg::IdW'(1)
                                              : next_id + tccc_pkg::IdW'(1);
          held_strike_next  = s1_strike;
          held_confirm_next = s1_time;
          deadline_next     = {1'b0, s1_strike}
                              + {{(tccc_pkg::WideW - tccc_pkg::CfgW - 1){1'b0}},
                                 cfg.post_margin};
          mode_next         = tccc_pkg::MODE_WAIT;
        end
      end else begin
        if (mode_eff != tccc_pkg::MODE_WAIT) begin
          r_disp = tccc_pkg::DISP_NONE_PENDING;
        end else if (now_w < deadline) begin
          r_disp = tccc_pkg::DISP_WAITING;
          r_id   = pending_id;
        end else if (age_held > slack_w) begin
          r_disp          = tccc_pkg::DISP_EXPIRED;
          r_id            = pending_id;
          pending_id_next = '0;
          mode_next       = tccc_pkg::MODE_READY;
        end else begin
          r_disp              = tccc_pkg::DISP_FREEZE;
          r_id                = pending_id;
          r_freeze            = 1'b1;
          r_start             = {1'b0, held_strike}
                                - {{(tccc_pkg::WideW - tccc_pkg::CfgW){1'b0}}, cfg.lead_span};
          r_end               = {1'b0, held_strike}
                                + {{(tccc_pkg::WideW - tccc_pkg::CfgW){1'b0}}, cfg.tail_span};
          last_frozen_id_next = pending_id;
          pending_id_next     = '0;
          if (cfg.cooldown_length == '0) begin
            mode_next = tccc_pkg::MODE_READY;
          end else begin
            cooldown_end_next = now_w
                                + {{(tccc_pkg::WideW - tccc_pkg::CfgW){1'b0}},
                                   cfg.cooldown_length};
            mode_next         = tccc_pkg::MODE_COOL;
          end
        end
      end
    end

    // session view after the request
    unique case (mode_next)
      tccc_pkg::MODE_WAIT: begin
        r_sess = tccc_pkg::SESS_WAIT;
        r_pdl  = deadline_next;
      end
      tccc_pkg::MODE_COOL: begin
        r_sess = tccc_pkg::SESS_COOL;
        r_pdl  = cooldown_end_next;
      end
      default: begin
        r_sess = tccc_pkg::SESS_READY;
        r_pdl  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= tccc_pkg::MODE_READY;
      next_id        <= tccc_pkg::IdW'(1);
      pending_id     <= '0;
      last_frozen_id <= '0;
      held_strike    <= '0;
      held_confirm   <= '0;
      deadline       <= '0;
      cooldown_end   <= '0;
      seen_time      <= 1'b0;
      last_time      <= '0;
    end else if (step) begin
      mode           <= mode_next;
      next_id        <= next_id_next;
      pending_id     <= pending_id_next;
      last_frozen_id <= last_frozen_id_next;
      held_strike    <= held_strike_next;
      held_confirm   <= held_confirm_next;
      deadline       <= deadline_next;
      cooldown_end   <= cooldown_end_next;
      seen_time      <= seen_time_next;
      last_time      <= last_time_next;
    end
  end

  // ---------------- result register ----------------
  tccc_pkg::disp_t out_disp;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_disp         <= r_disp;
      clip_id          <= r_id;
      freeze_valid     <= r_freeze;
      freeze_strike    <= r_freeze ? held_strike : '0;
      freeze_confirm   <= r_freeze ? held_confirm : '0;
      clip_start       <= r_start;
      clip_end         <= r_end;
      session_state    <= r_sess;
      pending_deadline <= r_pdl;
    end
  end

  assign disposition = out_disp;

  // ---------------- assertions ----------------
  a_wait_has_id: assert property (@(posedge clk) disable iff (rst)
    mode == tccc_pkg::MODE_WAIT |-> pending_id != '0)
    else $error("waiting with no pending clip id");

  a_next_id_nonzero: assert property (@(posedge clk) disable iff (rst)
    next_id != '0)
    else $error("next clip id is zero");

  a_accept_enters_wait: assert property (@(posedge clk) disable iff (rst)
    step && r_disp == tccc_pkg::DISP_ACCEPTED |=> mode == tccc_pkg::MODE_WAIT)
    else $error("accepted trigger did not arm the pending clip");

  a_error_keeps_state: assert property (@(posedge clk) disable iff (rst)
    step && (r_disp == tccc_pkg::DISP_CFG_INVALID || r_disp == tccc_pkg::DISP_CONFIRM_EARLY
             || r_disp == tccc_pkg::DISP_TIME_BACKWARDS)
    |=> $stable(mode) && $stable(pending_id) && $stable(last_time))
    else $error("error request changed controller state");

  a_result_after_step: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("decided request produced no result");

endmodule

### tb/tb_top.sv
module tb_top;

  localparam logic [tccc_pkg::TimeW-1:0] TimeMax = '1;
  localparam logic [tccc_pkg::CfgW-1:0]  CfgMax  = '1;

  // one request as offered on the input channel
  typedef struct packed {
    logic                       kind;
    logic [tccc_pkg::TimeW-1:0] strike;
    logic [tccc_pkg::TimeW-1:0] evt;
  } clip_req_t;

  // one result, field for field as on the output ports
  typedef struct packed {
    tccc_pkg::disp_t                   disp;
    logic [tccc_pkg::IdW-1:0]          id;
    logic                              fv;
    logic [tccc_pkg::TimeW-1:0]        fs;
    logic [tccc_pkg::TimeW-1:0]        fc;
    logic signed [tccc_pkg::WideW-1:0] cs;
    logic [tccc_pkg::WideW-1:0]        ce;
    logic [1:0]                        sess;
    logic [tccc_pkg::WideW-1:0]        dl;
  } outcome_t;

  logic                              clk;
  logic                              rst;
  logic                              in_valid;
  logic                              in_stall;
  logic                              req_type;
  logic [tccc_pkg::TimeW-1:0]        hit_time;
  logic [tccc_pkg::TimeW-1:0]        event_time;
  logic                              out_valid;
  logic                              out_stall;
  logic [3:0]                        disposition;
  logic [tccc_pkg::IdW-1:0]          clip_id;
  logic                              freeze_valid;
  logic [tccc_pkg::TimeW-1:0]        freeze_strike;
  logic [tccc_pkg::TimeW-1:0]        freeze_confirm;
  logic signed [tccc_pkg::WideW-1:0] clip_start;
  logic [tccc_pkg::WideW-1:0]        clip_end;
  logic [1:0]                        session_state;
  logic [tccc_pkg::WideW-1:0]        pending_deadline;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [tccc_pkg::IdxW-1:0]         cfg_index;
  logic [tccc_pkg::CfgW-1:0]         cfg_data;

  triggered_clip_capture_controller_top uut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .req_type         (req_type),
    .hit_time         (hit_time),
    .event_time       (event_time),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .disposition      (disposition),
    .clip_id          (clip_id),
    .freeze_valid     (freeze_valid),
    .freeze_strike    (freeze_strike),
    .freeze_confirm   (freeze_confirm),
    .clip_start       (clip_start),
    .clip_end         (clip_end),
    .session_state    (session_state),
    .pending_deadline (pending_deadline),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // 2-unit clock period
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Controller mirror: configuration copy and session state, updated once per
  // accepted request in acceptance order.
  // ---------------------------------------------------------------------------
  logic [tccc_pkg::CfgW-1:0]  cfg_pre    = '0;
  logic [tccc_pkg::CfgW-1:0]  cfg_post   = '0;
  logic [tccc_pkg::CfgW-1:0]  cfg_margin = '0;
  logic [tccc_pkg::CfgW-1:0]  cfg_ring   = '0;
  logic [tccc_pkg::CfgW-1:0]  cfg_cool   = '0;

  tccc_pkg::mode_t            ctl_mode     = tccc_pkg::MODE_READY;
  logic [tccc_pkg::IdW-1:0]   id_next      = 1;
  logic [tccc_pkg::IdW-1:0]   id_pending   = '0;
  logic [tccc_pkg::IdW-1:0]   id_frozen    = '0;
  logic [tccc_pkg::TimeW-1:0] kept_strike  = '0;
  logic [tccc_pkg::TimeW-1:0] kept_confirm = '0;
  logic [tccc_pkg::WideW-1:0] due_time     = '0;
  logic [tccc_pkg::WideW-1:0] cool_until   = '0;
  logic                       time_seen    = 1'b0;
  logic [tccc_pkg::TimeW-1:0] time_last    = '0;

  outcome_t outcomes_due[$];   // results owed by the block, oldest first
  int       mismatches   = 0;
  int       results_seen = 0;

  // stimulus time line; random traffic mostly moves forward along it
  logic [tccc_pkg::TimeW-1:0] wall = '0;

  // idle control: quiet drops all random gaps, rx_hold parks the receiver
  logic quiet   = 1'b0;
  logic rx_hold = 1'b0;
  int   rx_wait = 0;

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic clip_req_t make_request(logic kind, logic [tccc_pkg::TimeW-1:0] strike,
                                             logic [tccc_pkg::TimeW-1:0] at);
    clip_req_t q;
    q.kind   = kind;
    q.strike = strike;
    q.evt    = at;
    return q;
  endfunction

  // Decide the outcome of one request and advance the mirrored state.
  function automatic outcome_t decide_outcome(clip_req_t q);
    outcome_t   o;
    logic [63:0] need;
    logic [63:0] usable;
    o      = '0;
    need   = 64'(cfg_pre) + 64'(cfg_post) + 2 * 64'(cfg_margin);
    usable = 64'(cfg_ring) - 64'(cfg_margin);
    // error checks in priority order; none of them touches state
    if (64'(cfg_ring) < need) begin
      o.disp = tccc_pkg::DISP_CFG_INVALID;
    end else if (q.kind == tccc_pkg::REQ_TRIGGER && q.evt < q.strike) begin
      o.disp = tccc_pkg::DISP_CONFIRM_EARLY;
    end else if (time_seen && q.evt < time_last) begin
      o.disp = tccc_pkg::DISP_TIME_BACKWARDS;
    end else begin
      time_seen = 1'b1;
      time_last = q.evt;
      // cooldown expiry is evaluated before the request itself
      if (ctl_mode == tccc_pkg::MODE_COOL && 63'(q.evt) >= cool_until)
        ctl_mode = tccc_pkg::MODE_READY;
      if (q.kind == tccc_pkg::REQ_TRIGGER) begin
        if (ctl_mode == tccc_pkg::MODE_WAIT) begin
          o.disp = tccc_pkg::DISP_IGN_PENDING;
          o.id   = id_pending;
        end else if (ctl_mode == tccc_pkg::MODE_COOL) begin
          o.disp = tccc_pkg::DISP_IGN_COOLDOWN;
          o.id   = id_frozen;
        end else if (64'(q.evt) - 64'(q.strike) + 64'(cfg_pre) > usable) begin
          o.disp = tccc_pkg::DISP_PREROLL_GONE;
        end else begin
          id_pending   = id_next;
          id_next      = (id_next == '1) ? 32'd1 : id_next + 32'd1;
          kept_strike  = q.strike;
          kept_confirm = q.evt;
          due_time     = 63'(q.strike) + 63'(cfg_post) + 63'(cfg_margin);
          ctl_mode     = tccc_pkg::MODE_WAIT;
          o.disp       = tccc_pkg::DISP_ACCEPTED;
          o.id         = id_pending;
        end
      end else begin
        if (ctl_mode != tccc_pkg::MODE_WAIT) begin
          o.disp = tccc_pkg::DISP_NONE_PENDING;
        end else if (63'(q.evt) < due_time) begin
          o.disp = tccc_pkg::DISP_WAITING;
          o.id   = id_pending;
        end else if (64'(q.evt) - 64'(kept_strike) + 64'(cfg_pre) > usable) begin
          o.disp     = tccc_pkg::DISP_EXPIRED;
          o.id       = id_pending;
          id_pending = '0;
          ctl_mode   = tccc_pkg::MODE_READY;
        end else begin
          o.disp     = tccc_pkg::DISP_FREEZE;
          o.id       = id_pending;
          o.fv       = 1'b1;
          o.fs       = kept_strike;
          o.fc       = kept_confirm;
          o.cs       = 63'(64'(kept_strike) - 64'(cfg_pre));
          o.ce       = 63'(kept_strike) + 63'(cfg_post);
          id_frozen  = id_pending;
          id_pending = '0;
          if (cfg_cool == '0) begin
            ctl_mode = tccc_pkg::MODE_READY;
          end else begin
            cool_until = 63'(q.evt) + 63'(cfg_cool);
            ctl_mode   = tccc_pkg::MODE_COOL;
          end
        end
      end
    end
    case (ctl_mode)
      tccc_pkg::MODE_WAIT: begin
        o.sess = tccc_pkg::SESS_WAIT;
        o.dl   = due_time;
      end
      tccc_pkg::MODE_COOL: begin
        o.sess = tccc_pkg::SESS_COOL;
        o.dl   = cool_until;
      end
      default: begin
        o.sess = tccc_pkg::SESS_READY;
        o.dl   = '0;
      end
    endcase
    return o;
  endfunction

  task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at result %0d: %s expected %h got %h", results_seen, what, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall pattern and checking
  // ---------------------------------------------------------------------------
  // Wait count only runs down while a result is offered, so stalls land on
  // arbitrary points of the pipeline.
  always @(negedge clk) begin
    if (rx_hold) begin
      out_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      out_stall <= 1'b1;
      if (out_valid) rx_wait <= rx_wait - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_valid && !out_stall) begin
      rx_wait <= quiet ? 0 : $urandom_range(0, 5);
      results_seen++;
      if (outcomes_due.size() == 0) begin
        note_mismatch("result with nothing expected, disposition", '0, disposition);
      end else begin
        want = outcomes_due.pop_front();
        if (disposition !== want.disp)
          note_mismatch("disposition", want.disp, disposition);
        if (clip_id !== want.id)
          note_mismatch("clip_id", want.id, clip_id);
        if (freeze_valid !== want.fv)
          note_mismatch("freeze_valid", want.fv, freeze_valid);
        if (freeze_strike !== want.fs)
          note_mismatch("freeze_strike", want.fs, freeze_strike);
        if (freeze_confirm !== want.fc)
          note_mismatch("freeze_confirm", want.fc, freeze_confirm);
        if (clip_start !== want.cs)
          note_mismatch("clip_start", want.cs, clip_start);
        if (clip_end !== want.ce)
          note_mismatch("clip_end", want.ce, clip_end);
        if (session_state !== want.sess)
          note_mismatch("session_state", want.sess, session_state);
        if (pending_deadline !== want.dl)
          note_mismatch("pending_deadline", want.dl, pending_deadline);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Offer one request; valid is only lowered when a gap is drawn, so back to
  // back requests keep it high with no extra edge.
  task automatic send_req(clip_req_t q);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_type    <= q.kind;
    hit_time    <= q.strike;
    event_time  <= q.evt;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_stall);
    outcomes_due.push_back(decide_outcome(q));
  endtask

  // Stop requesting and wait for every owed result, plus pipeline slack.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outcomes_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [tccc_pkg::IdxW-1:0] idx, logic [tccc_pkg::CfgW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      tccc_pkg::CFG_LEAD_SPAN:       cfg_pre    = val;
      tccc_pkg::CFG_TAIL_SPAN:       cfg_post   = val;
      tccc_pkg::CFG_BOUNDARY_MARGIN: cfg_margin = val;
      tccc_pkg::CFG_RING_RETENTION:  cfg_ring   = val;
      tccc_pkg::CFG_COOLDOWN_LENGTH: cfg_cool   = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Registers change only with the block idle; derived terms settle after.
  task automatic set_config(logic [tccc_pkg::CfgW-1:0] pre, logic [tccc_pkg::CfgW-1:0] post,
                            logic [tccc_pkg::CfgW-1:0] margin,
                            logic [tccc_pkg::CfgW-1:0] ring,
                            logic [tccc_pkg::CfgW-1:0] cool);
    drain();
    write_reg(tccc_pkg::CFG_LEAD_SPAN, pre);
    write_reg(tccc_pkg::CFG_TAIL_SPAN, post);
    write_reg(tccc_pkg::CFG_BOUNDARY_MARGIN, margin);
    write_reg(tccc_pkg::CFG_RING_RETENTION, ring);
    write_reg(tccc_pkg::CFG_COOLDOWN_LENGTH, cool);
    repeat (2) @(negedge clk);
  endtask

  // Next random request around the time line. Mostly forward-moving ticks
  // and triggers with a strike a little behind; a few time-backwards and
  // confirm-before-strike requests as noise.
  function automatic clip_req_t next_request(logic [63:0] scale);
    clip_req_t   q;
    logic [63:0] lag;
    logic [63:0] step;
    int          pick;
    pick     = $urandom_range(0, 99);
    q.kind   = $urandom_range(0, 1) ? tccc_pkg::REQ_TICK : tccc_pkg::REQ_TRIGGER;
    q.strike = 62'(rnd64());
    q.evt    = wall;
    lag      = rnd64() % (scale + 1);
    if (pick < 4 && wall != '0) begin
      if (lag >= 64'(wall)) lag = 64'(wall) - 1;
      q.evt = wall - 62'(lag) - 62'd1;
      if (q.kind == tccc_pkg::REQ_TRIGGER) q.strike = q.evt;
    end else if (pick < 8) begin
      q.kind   = tccc_pkg::REQ_TRIGGER;
      q.strike = (64'(TimeMax) - 64'(wall) > lag) ? wall + 62'(lag) + 62'd1 : TimeMax;
    end else begin
      case ($urandom_range(0, 9))
        0:       step = '0;
        1:       step = rnd64() % (4 * scale);
        default: step = rnd64() % (scale / 2 + 1);
      endcase
      wall  = (64'(TimeMax) - 64'(wall) < step) ? TimeMax : wall + 62'(step);
      q.evt = wall;
      if (q.kind == tccc_pkg::REQ_TRIGGER) q.strike = (lag > 64'(wall)) ? '0 : wall - 62'(lag);
    end
    return q;
  endfunction

  // Random register set scaled to the time steps; one in ten is inconsistent.
  task automatic pick_setting(output logic [63:0] scale);
    logic [63:0] pre, post, margin, ring, cool, need;
    case ($urandom_range(0, 9))
      0, 1:    scale = 64'd1 << 36;
      2, 3, 4: scale = 64'd1 << 16;
      default: scale = 64'd1 << $urandom_range(5, 9);
    endcase
    pre    = ($urandom_range(0, 7) == 0) ? '0 : rnd64() % scale;
    post   = rnd64() % scale;
    margin = ($urandom_range(0, 7) == 0) ? '0 : rnd64() % (scale / 4 + 1);
    need   = pre + post + 2 * margin;
    ring   = need + rnd64() % scale;
    if ($urandom_range(0, 9) == 0 && need != 0) ring = rnd64() % need;
    cool   = ($urandom_range(0, 3) == 0) ? '0 : rnd64() % scale;
    set_config(40'(pre), 40'(post), 40'(margin), 40'(ring), 40'(cool));
    quiet = ($urandom_range(0, 3) == 0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // All registers zero after reset: a zero-length clip at time zero.
  task automatic test_reset_values();
    send_req(make_request(tccc_pkg::REQ_TRIGGER, '0, '0));
    send_req(make_request(tccc_pkg::REQ_TICK, '0, '0));
    send_req(make_request(tccc_pkg::REQ_TICK, TimeMax, '0));
  endtask

  // Inconsistent registers reject everything, whatever the fields hold.
  task automatic test_bad_config();
    set_config(40'd5, '0, '0, '0, '0);
    repeat (10) begin
      send_req(make_request($urandom_range(0, 1) ? tccc_pkg::REQ_TICK : tccc_pkg::REQ_TRIGGER,
                            62'(rnd64()), 62'(rnd64())));
    end
    // indexes past the register list must be harmless
    drain();
    for (int k = int'(tccc_pkg::CFG_COOLDOWN_LENGTH) + 1; k < (1 << tccc_pkg::IdxW); k++)
      write_reg(tccc_pkg::IdxW'(k), 40'(rnd64()));
    set_config(CfgMax, CfgMax, CfgMax, CfgMax, CfgMax);
    repeat (6) begin
      send_req(make_request($urandom_range(0, 1) ? tccc_pkg::REQ_TICK : tccc_pkg::REQ_TRIGGER,
                            62'(rnd64()), 62'(rnd64())));
    end
  endtask

  // Walk the session through every disposition; usable ring is 95 ticks.
  task automatic test_dispositions();
    logic [tccc_pkg::TimeW-1:0] t0;
    t0 = wall + 62'd1000;
    set_config(40'd10, 40'd20, 40'd5, 40'd100, 40'd30);
    send_req(make_request(tccc_pkg::REQ_TRIGGER, t0, t0 - 62'd1));           // confirm early
    send_req(make_request(tccc_pkg::REQ_TICK, '0, t0));                      // nothing pending
    send_req(make_request(tccc_pkg::REQ_TRIGGER, t0 - 62'd100, t0));         // pre-roll gone
    send_req(make_request(tccc_pkg::REQ_TRIGGER, t0 - 62'd10, t0));          // accepted
    send_req(make_request(tccc_pkg::REQ_TRIGGER, t0 - 62'd5, t0 + 62'd1));   // already pending
    send_req(make_request(tccc_pkg::REQ_TICK, '0, t0 + 62'd5));              // waiting
    send_req(make_request(tccc_pkg::REQ_TICK, '0, t0 + 62'd4));              // backwards
    // confirm-early wins over backwards
    send_req(make_request(tccc_pkg::REQ_TRIGGER, t0 + 62'd20, t0 + 62'd4));
    send_req(make_request(tccc_pkg::REQ_TICK, '0, t0 + 62'd15));             // freeze
    send_req(make_request(tccc_pkg::REQ_TRIGGER, t0 + 62'd20, t0 + 62'd20)); // in cooldown
    send_req(make_request(tccc_pkg::REQ_TICK, '0, t0 + 62'd44));             // tick in cooldown
    // trigger exactly at cooldown end is taken
    send_req(make_request(tccc_pkg::REQ_TRIGGER, t0 + 62'd45, t0 + 62'd45));
    send_req(make_request(tccc_pkg::REQ_TICK, '0, t0 + 62'd250));            // expired
    wall = t0 + 62'd250;
  endtask

  // Full-scale registers: negative clip start, longest cooldown and post-roll.
  task automatic test_register_extremes();
    set_config(CfgMax, '0, '0, CfgMax, CfgMax);
    send_req(make_request(tccc_pkg::REQ_TRIGGER, wall, wall));
    send_req(make_request(tccc_pkg::REQ_TICK, '0, wall));
    send_req(make_request(tccc_pkg::REQ_TRIGGER, wall + 62'd5, wall + 62'd5));
    send_req(make_request(tccc_pkg::REQ_TICK, '0, wall + CfgMax - 62'd1));
    // tick right at cooldown end drops back to ready
    send_req(make_request(tccc_pkg::REQ_TICK, '0, wall + CfgMax));
    send_req(make_request(tccc_pkg::REQ_TRIGGER, '0, wall + CfgMax));
    wall = wall + CfgMax;
    set_config('0, CfgMax, '0, CfgMax, '0);
    send_req(make_request(tccc_pkg::REQ_TRIGGER, wall, wall));
    send_req(make_request(tccc_pkg::REQ_TICK, '0, wall + CfgMax));
    wall = wall + CfgMax;
    set_config('0, '0, CfgMax, CfgMax, '0);
    send_req(make_request(tccc_pkg::REQ_TRIGGER, wall, wall));
  endtask

  // Receiver parks while requests keep coming back to back.
  task automatic test_backpressure();
    set_config(40'd10, 40'd20, 40'd5, 40'd100, '0);
    quiet = 1'b1;
    rx_hold <= 1'b1;
    fork
      begin
        repeat (60) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    repeat (24) send_req(next_request(64'd64));
  endtask

  task automatic test_random_traffic();
    logic [63:0] scale;
    int          n;
    int          burst;
    bit          high_done;
    n         = 0;
    high_done = 1'b0;
    while (n < 980) begin
      // late in the run move the time line up near the top of the range
      if (!high_done && n >= 800) begin
        wall      = TimeMax - 62'(64'd1 << 46) - 62'(rnd64() % (64'd1 << 40));
        high_done = 1'b1;
      end
      pick_setting(scale);
      burst = $urandom_range(40, 120);
      repeat (burst) send_req(next_request(scale));
      n += burst;
    end
  endtask

  // Requests at the largest representable time.
  task automatic test_time_ceiling();
    set_config(40'd10, 40'd20, 40'd5, 40'd100, '0);
    quiet = 1'b0;
    send_req(make_request(tccc_pkg::REQ_TRIGGER, TimeMax, TimeMax));
    send_req(make_request(tccc_pkg::REQ_TICK, '0, TimeMax));
    send_req(make_request(tccc_pkg::REQ_TRIGGER, TimeMax - 62'd3, TimeMax));
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    req_type    = tccc_pkg::REQ_TRIGGER;
    hit_time    = '0;
    event_time  = '0;
    out_stall   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_bad_config();
    test_dispositions();
    test_register_extremes();
    test_backpressure();
    test_random_traffic();
    test_time_ceiling();

    // flush: bounded wait for the last results, then an idle pause
    @(negedge clk);
    in_valid <= 1'b0;
    for (int k = 0; k < 5000 && outcomes_due.size() != 0; k++) @(negedge clk);
    repeat (10) @(negedge clk);
    if (outcomes_due.size() != 0)
      note_mismatch("results never delivered, count", outcomes_due.size(), '0);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

endmodule

### filelist.f
hdl/tccc_pkg.sv
hdl/tccc_cfg.sv
hdl/triggered_clip_capture_controller_top.sv
tb/tb_top.sv
